[hw/rtl/lpud_pkg.sv]
`default_nettype none

package lpud_pkg;

  // Width of the length header and of the max_payload register
  localparam int unsigned HDR_W = 32;
  // Widest payload length that the frame format allows
  localparam int unsigned LENGTH_BITS = 32;
  localparam logic [HDR_W-1:0] MAX_PAYLOAD_RST = 32'h0100_0000;

  // Result queue between the front and back parts
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_HALT    = 2'd2
  } phase_t;

  // Range that the byte after a lead byte must fall in
  typedef enum logic [2:0] {
    RULE_ANY   = 3'd0,
    RULE_A0_BF = 3'd1,
    RULE_80_9F = 3'd2,
    RULE_90_BF = 3'd3,
    RULE_80_8F = 3'd4
  } rule_t;

  typedef enum logic [2:0] {
    ST_BYTE   = 3'd0,
    ST_OK     = 3'd1,
    ST_BADLEN = 3'd2,
    ST_BADUTF = 3'd3,
    ST_HALT   = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_last;
    status_t    status;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t res;
  } q_push_t;

  typedef struct packed {
    logic    full;
    logic    nonempty;
    result_t head;
  } q_stat_t;

endpackage

`default_nettype wire

[hw/rtl/lpud_if.sv]
`default_nettype none

interface lpud_in_if import lpud_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface lpud_out_if import lpud_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_last;
  status_t    status;

  modport source (output valid, output out_byte, output is_last, output status, input ready);
  modport sink (input valid, input out_byte, input is_last, input status, output ready);
endinterface

interface lpud_cfg_if import lpud_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HDR_W-1:0] max_payload;

  modport source (output valid, output max_payload, input ready);
  modport sink (input valid, input max_payload, output ready);
endinterface

`default_nettype wire

[hw/rtl/lpud_front.sv]
`default_nettype none

module lpud_front import lpud_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lpud_in_if.sink     in_chan,
  lpud_cfg_if.sink    cfg_chan,
  input  q_stat_t     q_stat,
  output q_push_t     q_push
);

  logic [HDR_W-1:0]       max_payload_r;
  phase_t                 phase_r, phase_nxt;
  logic [1:0]             hdr_cnt_r, hdr_cnt_nxt;
  logic [HDR_W-9:0]       len_shift_r, len_shift_nxt;
  logic [LENGTH_BITS-1:0] bytes_left_r, bytes_left_nxt;
  logic [1:0]             pend_r, pend_nxt;
  rule_t                  rule_r, rule_nxt;
  logic                   bad_r, bad_nxt;

  logic                   accept;
  logic [7:0]             b;
  logic [HDR_W-1:0]       len;
  logic                   len_bad;
  logic [7:0]             lo, hi;
  logic [1:0]             feed_pend;
  rule_t                  feed_rule;
  logic                   feed_bad;
  logic                   frame_bad;

  assign in_chan.ready  = !q_stat.full;
  assign cfg_chan.ready = 1'b1;
  assign accept         = in_chan.valid && in_chan.ready;
  assign b              = in_chan.in_byte;
  assign len            = {len_shift_r, b};
  assign len_bad        = (len == '0) || (len > max_payload_r) ||
                          ((len >> LENGTH_BITS) != '0);

  // UTF-8 check for one payload byte
  always_comb begin
    lo        = 8'h80;
    hi        = 8'hbf;
    feed_pend = pend_r;
    feed_rule = RULE_ANY;
    feed_bad  = bad_r;
    if (pend_r != 2'd0) begin
      case (rule_r)
        RULE_A0_BF: lo = 8'ha0;
        RULE_80_9F: hi = 8'h9f;
        RULE_90_BF: lo = 8'h90;
        RULE_80_8F: hi = 8'h8f;
        default: ;
      endcase
      if (b < lo || b > hi) begin
        feed_bad = 1'b1;
      end
      feed_pend = pend_r - 2'd1;
    end else if (b <= 8'h7f) begin
      feed_pend = 2'd0;
    end else if (b >= 8'hc2 && b <= 8'hdf) begin
      feed_pend = 2'd1;
    end else if (b >= 8'he0 && b <= 8'hef) begin
      feed_pend = 2'd2;
      if (b == 8'he0) begin
        feed_rule = RULE_A0_BF;
      end else if (b == 8'hed) begin
        feed_rule = RULE_80_9F;
      end
    end else if (b >= 8'hf0 && b <= 8'hf4) begin
      feed_pend = 2'd3;
      if (b == 8'hf0) begin
        feed_rule = RULE_90_BF;
      end else if (b == 8'hf4) begin
        feed_rule = RULE_80_8F;
      end
    end else begin
      feed_bad = 1'b1;
    end
  end

  assign frame_bad = feed_bad || (feed_pend != 2'd0);

  // Next state
  always_comb begin
    phase_nxt      = phase_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    len_shift_nxt  = len_shift_r;
    bytes_left_nxt = bytes_left_r;
    pend_nxt       = pend_r;
    rule_nxt       = rule_r;
    bad_nxt        = bad_r;
    if (accept) begin
      case (phase_r)
        PH_HEADER: begin
          hdr_cnt_nxt = hdr_cnt_r + 2'd1;
          if (hdr_cnt_r != 2'd3) begin
            len_shift_nxt = {len_shift_r[HDR_W-17:0], b};
          end else begin
            len_shift_nxt = '0;
            if (len_bad) begin
              phase_nxt = PH_HALT;
            end else begin
              phase_nxt      = PH_PAYLOAD;
              bytes_left_nxt = len[LENGTH_BITS-1:0];
              pend_nxt       = 2'd0;
              rule_nxt       = RULE_ANY;
              bad_nxt        = 1'b0;
            end
          end
        end
        PH_PAYLOAD: begin
          if (bytes_left_r > LENGTH_BITS'(1)) begin
            bytes_left_nxt = bytes_left_r - LENGTH_BITS'(1);
            pend_nxt       = feed_pend;
            rule_nxt       = feed_rule;
            bad_nxt        = feed_bad;
          end else begin
            bytes_left_nxt = '0;
            pend_nxt       = 2'd0;
            rule_nxt       = RULE_ANY;
            bad_nxt        = frame_bad;
            phase_nxt      = frame_bad ? PH_HALT : PH_HEADER;
          end
        end
        default: ;
      endcase
    end
  end

  // Result toward the queue
  always_comb begin
    q_push.push         = 1'b0;
    q_push.res.out_byte = 8'd0;
    q_push.res.is_last  = 1'b0;
    q_push.res.status   = ST_HALT;
    case (phase_r)
      PH_HEADER: begin
        q_push.push       = accept && (hdr_cnt_r == 2'd3) && len_bad;
        q_push.res.status = ST_BADLEN;
      end
      PH_PAYLOAD: begin
        q_push.push         = accept;
        q_push.res.out_byte = b;
        if (bytes_left_r > LENGTH_BITS'(1)) begin
          q_push.res.status = ST_BYTE;
        end else begin
          q_push.res.is_last = 1'b1;
          q_push.res.status  = frame_bad ? ST_BADUTF : ST_OK;
        end
      end
      default: begin
        q_push.push = accept;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
      phase_r       <= PH_HEADER;
      hdr_cnt_r     <= 2'd0;
      len_shift_r   <= '0;
      bytes_left_r  <= '0;
      pend_r        <= 2'd0;
      rule_r        <= RULE_ANY;
      bad_r         <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        max_payload_r <= cfg_chan.max_payload;
      end
      phase_r      <= phase_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      len_shift_r  <= len_shift_nxt;
      bytes_left_r <= bytes_left_nxt;
      pend_r       <= pend_nxt;
      rule_r       <= rule_nxt;
      bad_r        <= bad_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lpud_queue.sv]
`default_nettype none

module lpud_queue import lpud_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  q_push_t   q_push,
  input  wire logic pop,
  output q_stat_t   q_stat
);

  result_t             mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]   count_r;
  logic                do_push, do_pop;

  assign q_stat.full     = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign q_stat.nonempty = (count_r != '0);
  assign q_stat.head     = mem[rd_ptr_r];

  assign do_push = q_push.push && !q_stat.full;
  assign do_pop  = pop && q_stat.nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= q_push.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (QUEUE_AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (QUEUE_AW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lpud_back.sv]
`default_nettype none

module lpud_back import lpud_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  q_stat_t   q_stat,
  output logic      pop,
  lpud_out_if.source out_chan
);

  logic    out_valid_r;
  result_t out_res_r;

  // Refill the output register when it is empty or being drained
  assign pop = q_stat.nonempty && (!out_valid_r || out_chan.ready);

  assign out_chan.valid    = out_valid_r;
  assign out_chan.out_byte = out_res_r.out_byte;
  assign out_chan.is_last  = out_res_r.is_last;
  assign out_chan.status   = out_res_r.status;

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res_r <= q_stat.head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/length_prefixed_utf8_deframer_unit.sv]
`default_nettype none

// Length-prefixed UTF-8 deframer. Feed the framed byte stream one byte per
// in_chan transaction: four big-endian header bytes give the payload length,
// then the payload follows. A length of zero or above max_payload yields one
// status-only result (bad length) and halts the block. Each payload byte comes
// back on out_chan with status "payload byte"; the last one carries is_last
// and the verdict of a strict UTF-8 check (frame valid or bad UTF-8). A bad
// frame also halts the block; while halted every input byte yields a
// "halted" result until rst_n is asserted. Header bytes that are good yield
// nothing. The block takes one byte per clock cycle: the front part decodes
// each byte combinationally, and a 4-entry result queue plus an output
// register keep input flowing while out_chan stalls. in_chan.ready drops only
// when that queue is full. A result reaches out_chan through the queue and
// then the output register. Write max_payload through cfg_chan only while no
// frame is in flight; cfg_chan is always ready.
module length_prefixed_utf8_deframer_unit import lpud_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lpud_in_if.sink    in_chan,
  lpud_cfg_if.sink   cfg_chan,
  lpud_out_if.source out_chan
);

  q_push_t q_push;
  q_stat_t q_stat;
  logic    pop;

  // Front: header assembly, length check, UTF-8 check, phase control
  lpud_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg_chan (cfg_chan),
    .q_stat   (q_stat),
    .q_push   (q_push)
  );

  // Queue: decouple decode from output backpressure
  lpud_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (pop),
    .q_stat (q_stat)
  );

  // Back: drive results out through a registered stage
  lpud_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

[tb/sv/deframe_checker.sv]
// Watches the byte, result and max_payload channels of the deframer, predicts
// every result from the accepted bytes and compares it with what comes out.
module deframe_checker import lpud_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [HDR_W-1:0] cfg_max_payload,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [7:0]       out_byte,
  input  logic             out_is_last,
  input  status_t          out_status,
  output int               mismatches,
  output int               results_owed,
  output int               results_checked,
  output int               frames_passed
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted deframer state
  logic [HDR_W-1:0] size_limit;
  phase_t           frame_phase;
  logic [1:0]       hdr_taken;
  logic [31:0]      hdr_len;
  logic [31:0]      payload_left;
  logic [1:0]       conts_owed;
  rule_t            next_rule;
  logic             text_bad;

  result_t result_due[$];
  int      fail_total = 0;
  int      check_total = 0;
  int      pass_total = 0;

  task automatic clear_prediction();
    size_limit   = MAX_PAYLOAD_RST;
    frame_phase  = PH_HEADER;
    hdr_taken    = 2'd0;
    hdr_len      = '0;
    payload_left = '0;
    conts_owed   = 2'd0;
    next_rule    = RULE_ANY;
    text_bad     = 1'b0;
    result_due.delete();
  endtask

  // Advance the UTF-8 checker by one payload byte.
  task automatic scan_utf8(input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    if (conts_owed != 2'd0) begin
      lo = 8'h80;
      hi = 8'hbf;
      case (next_rule)
        RULE_A0_BF: lo = 8'ha0;
        RULE_80_9F: hi = 8'h9f;
        RULE_90_BF: lo = 8'h90;
        RULE_80_8F: hi = 8'h8f;
        default: ;
      endcase
      if (b < lo || b > hi) text_bad = 1'b1;
      next_rule  = RULE_ANY;
      conts_owed = conts_owed - 2'd1;
    end else begin
      next_rule = RULE_ANY;
      if (b >= 8'hc2 && b <= 8'hdf) begin
        conts_owed = 2'd1;
      end else if (b >= 8'he0 && b <= 8'hef) begin
        conts_owed = 2'd2;
        if (b == 8'he0) next_rule = RULE_A0_BF;
        else if (b == 8'hed) next_rule = RULE_80_9F;
      end else if (b >= 8'hf0 && b <= 8'hf4) begin
        conts_owed = 2'd3;
        if (b == 8'hf0) next_rule = RULE_90_BF;
        else if (b == 8'hf4) next_rule = RULE_80_8F;
      end else if (b >= 8'h80) begin
        text_bad = 1'b1;
      end
    end
  endtask

  // Predict the result, if any, of one accepted byte.
  task automatic deframe_byte(input logic [7:0] b);
    result_t     r;
    logic [31:0] len;
    r.out_byte = 8'h00;
    r.is_last  = 1'b0;
    r.status   = ST_HALT;
    case (frame_phase)
      PH_HEADER: begin
        len       = {hdr_len[23:0], b};
        hdr_taken = hdr_taken + 2'd1;
        if (hdr_taken != 2'd0) begin
          hdr_len = len;
        end else begin
          hdr_len = '0;
          if (len == 0 || len > size_limit || (len >> LENGTH_BITS) != 0) begin
            frame_phase = PH_HALT;
            r.status    = ST_BADLEN;
            result_due.push_back(r);
          end else begin
            payload_left = len;
            conts_owed   = 2'd0;
            next_rule    = RULE_ANY;
            text_bad     = 1'b0;
            frame_phase  = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        scan_utf8(b);
        r.out_byte = b;
        if (payload_left > 1) begin
          payload_left = payload_left - 1;
          r.status     = ST_BYTE;
        end else begin
          payload_left = '0;
          if (conts_owed != 2'd0) text_bad = 1'b1;
          r.is_last = 1'b1;
          if (text_bad) begin
            frame_phase = PH_HALT;
            r.status    = ST_BADUTF;
          end else begin
            frame_phase = PH_HEADER;
            r.status    = ST_OK;
            pass_total++;
          end
          conts_owed = 2'd0;
          next_rule  = RULE_ANY;
        end
        result_due.push_back(r);
      end
      default: result_due.push_back(r);
    endcase
  endtask

  task automatic compare_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fail_total++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_prediction();
    end else begin
      // Compare before predicting, so a result can never match its own byte.
      if (out_valid && out_ready) begin
        if (result_due.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual byte %0d last %0d status %0d",
                   $time, out_byte, out_is_last, out_status);
          fail_total++;
        end else begin
          compare_field("out_byte", result_due[0].out_byte, out_byte);
          compare_field("is_last", result_due[0].is_last, out_is_last);
          compare_field("status", result_due[0].status, out_status);
          void'(result_due.pop_front());
        end
        check_total++;
      end
      if (cfg_valid && cfg_ready) size_limit = cfg_max_payload;
      if (in_valid && in_ready) deframe_byte(in_byte);
    end
    mismatches      <= fail_total;
    results_owed    <= result_due.size();
    results_checked <= check_total;
    frames_passed   <= pass_total;
  end

endmodule

[tb/sv/length_prefixed_utf8_deframer_unit_test.sv]
// Top of the deframer regression: drives framed byte streams and max_payload
// writes, lets the receiver stall on its own, and reports the verdict that
// the checker's mismatch count and leftover expectations decide.
module length_prefixed_utf8_deframer_unit_test;
  import lpud_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Leave margin before touching max_payload.
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 120;
  localparam int PHASE_BYTES   = 190;

  // Ways to break the stream at the end of the run. The block halts for
  // good on any error, so only one of them can be reached per run.
  typedef enum int {
    FAULT_ZERO_LEN,
    FAULT_OVER_LEN,
    FAULT_OVERLONG2,
    FAULT_OVERLONG3,
    FAULT_SURROGATE,
    FAULT_OVERLONG4,
    FAULT_ABOVE_MAX,
    FAULT_BAD_LEAD,
    FAULT_STRAY_CONT,
    FAULT_BAD_CONT,
    FAULT_TRUNCATED
  } fault_t;

  logic clk = 1'b0;
  logic rst_n;

  lpud_in_if  in_chan ();
  lpud_cfg_if cfg_chan ();
  lpud_out_if out_chan ();

  int mismatches;
  int results_owed;
  int results_checked;
  int frames_passed;

  // Payload under construction and run bookkeeping
  logic [7:0]  text[$];
  logic [31:0] cur_limit = MAX_PAYLOAD_RST;
  int unsigned burst_left = 0;
  int unsigned bytes_sent = 0;
  int unsigned limit_writes = 0;
  int unsigned halted_bytes = 0;
  bit          hold_off_req = 1'b0;
  int unsigned holds_done = 0;
  fault_t      fault;

  always #10 clk = ~clk;

  length_prefixed_utf8_deframer_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg_chan (cfg_chan),
    .out_chan (out_chan)
  );

  deframe_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_chan.valid),
    .in_ready        (in_chan.ready),
    .in_byte         (in_chan.in_byte),
    .cfg_valid       (cfg_chan.valid),
    .cfg_ready       (cfg_chan.ready),
    .cfg_max_payload (cfg_chan.max_payload),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_byte        (out_chan.out_byte),
    .out_is_last     (out_chan.is_last),
    .out_status      (out_chan.status),
    .mismatches      (mismatches),
    .results_owed    (results_owed),
    .results_checked (results_checked),
    .frames_passed   (frames_passed)
  );

  // Offer one byte and hold it until the transaction completes. The sender
  // runs in bursts; a new burst may open with a random gap, and now and then
  // a long burst keeps the input saturated.
  task automatic offer_byte(input logic [7:0] b);
    int unsigned idle;
    if (burst_left == 0) begin
      idle       = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 20);
      if (idle != 0) begin
        in_chan.valid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
    burst_left--;
    in_chan.valid   <= 1'b1;
    in_chan.in_byte <= b;
    do @(posedge clk); while (!in_chan.ready);
    bytes_sent++;
  endtask

  // Send the four header bytes, most significant first.
  task automatic send_length(input logic [31:0] len);
    offer_byte(len[31:24]);
    offer_byte(len[23:16]);
    offer_byte(len[15:8]);
    offer_byte(len[7:0]);
  endtask

  // Frame whatever is in the payload buffer and send it.
  task automatic send_frame();
    send_length(text.size());
    foreach (text[i]) offer_byte(text[i]);
  endtask

  // Drop valid and wait until every predicted result has come back, then let
  // the block settle, since header bytes give nothing to wait for.
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_payload(input logic [31:0] v);
    cfg_chan.valid       <= 1'b1;
    cfg_chan.max_payload <= v;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    cur_limit = v;
    limit_writes++;
  endtask

  // Append the UTF-8 encoding of a code point of the given byte width.
  task automatic add_code_point(input logic [20:0] cp, input int unsigned w);
    case (w)
      1: text.push_back(cp[7:0]);
      2: begin
        text.push_back({3'b110, cp[10:6]});
        text.push_back({2'b10, cp[5:0]});
      end
      3: begin
        text.push_back({4'b1110, cp[15:12]});
        text.push_back({2'b10, cp[11:6]});
        text.push_back({2'b10, cp[5:0]});
      end
      default: begin
        text.push_back({5'b11110, cp[20:18]});
        text.push_back({2'b10, cp[17:12]});
        text.push_back({2'b10, cp[11:6]});
        text.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // Append one random valid character no wider than room bytes. Favor ASCII
  // and hit the range edges of each width now and then.
  task automatic add_random_char(input int unsigned room);
    int unsigned w;
    int unsigned top_w;
    logic [20:0] lo_cp;
    logic [20:0] hi_cp;
    logic [20:0] cp;
    top_w = (room < 4) ? room : 4;
    w     = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(1, top_w);
    case (w)
      1: begin
        lo_cp = 21'h0;
        hi_cp = 21'h7f;
      end
      2: begin
        lo_cp = 21'h80;
        hi_cp = 21'h7ff;
      end
      3: begin
        lo_cp = 21'h800;
        hi_cp = 21'hffff;
      end
      default: begin
        lo_cp = 21'h10000;
        hi_cp = 21'h10ffff;
      end
    endcase
    cp = 21'($urandom_range(hi_cp, lo_cp));
    if ($urandom_range(0, 7) == 0) cp = $urandom_range(0, 1) ? lo_cp : hi_cp;
    // Land on the edges of the surrogate gap rather than inside it.
    if (cp >= 21'hd800 && cp <= 21'hdfff) cp = $urandom_range(0, 1) ? 21'hd7ff : 21'he000;
    add_code_point(cp, w);
  endtask

  task automatic fill_text(input int unsigned target);
    while (text.size() < target) add_random_char(target - text.size());
  endtask

  task automatic send_random_frame();
    int unsigned cap;
    int unsigned target;
    cap = (cur_limit < 40) ? cur_limit : 40;
    if (cur_limit > 150 && $urandom_range(0, 19) == 0) cap = 150;
    // Hit the exact max_payload boundary when the limit is small.
    target = ($urandom_range(0, 5) == 0) ? cap : $urandom_range(1, cap);
    text.delete();
    fill_text(target);
    send_frame();
  endtask

  task automatic add_continuation();
    text.push_back(8'($urandom_range(8'h80, 8'hbf)));
  endtask

  // Build a payload that carries the chosen UTF-8 fault between stretches of
  // valid text.
  task automatic build_faulty_text(input fault_t f);
    int unsigned w;
    text.delete();
    fill_text($urandom_range(0, 8));
    case (f)
      FAULT_OVERLONG2: begin
        text.push_back(8'($urandom_range(8'hc0, 8'hc1)));
        add_continuation();
      end
      FAULT_OVERLONG3: begin
        text.push_back(8'he0);
        text.push_back(8'($urandom_range(8'h80, 8'h9f)));
        add_continuation();
      end
      FAULT_SURROGATE: begin
        text.push_back(8'hed);
        text.push_back(8'($urandom_range(8'ha0, 8'hbf)));
        add_continuation();
      end
      FAULT_OVERLONG4: begin
        text.push_back(8'hf0);
        text.push_back(8'($urandom_range(8'h80, 8'h8f)));
        add_continuation();
        add_continuation();
      end
      FAULT_ABOVE_MAX: begin
        text.push_back(8'hf4);
        text.push_back(8'($urandom_range(8'h90, 8'hbf)));
        add_continuation();
        add_continuation();
      end
      FAULT_BAD_LEAD: text.push_back(8'($urandom_range(8'hf5, 8'hff)));
      FAULT_STRAY_CONT: add_continuation();
      FAULT_BAD_CONT: begin
        // The bad byte still counts toward the pending sequence.
        text.push_back(8'($urandom_range(8'hc2, 8'hf4)));
        if ($urandom_range(0, 1) == 1) text.push_back(8'($urandom_range(8'h00, 8'h7f)));
        else text.push_back(8'($urandom_range(8'hc0, 8'hff)));
      end
      default: begin
        // Cut a sequence off at the frame end.
        w = $urandom_range(2, 4);
        case (w)
          2: text.push_back(8'($urandom_range(8'hc2, 8'hdf)));
          3: text.push_back(8'($urandom_range(8'he1, 8'hec)));
          default: text.push_back(8'($urandom_range(8'hf1, 8'hf3)));
        endcase
        repeat ($urandom_range(0, w - 2)) add_continuation();
      end
    endcase
    if (f != FAULT_TRUNCATED) fill_text(text.size() + $urandom_range(0, 8));
  endtask

  // Receiver: alternate between full-speed stretches and random stall
  // densities; on request, hold off for a long stretch so the block fills.
  initial begin : receiver
    int unsigned span;
    int unsigned odds;
    out_chan.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        span = $urandom_range(4, 40);
        case ($urandom_range(0, 3))
          0: odds = 100;
          1: odds = 75;
          2: odds = 40;
          default: odds = 15;
        endcase
        repeat (span) begin
          out_chan.ready <= ($urandom_range(1, 100) <= odds);
          @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned quota;
    logic [31:0] lim;
    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.in_byte      <= 8'h00;
    cfg_chan.valid       <= 1'b0;
    cfg_chan.max_payload <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frame at the reset limit: the lowest and highest value of each
    // encoded width, the low second-byte bound after E0/F0 and the high after ED/F4.
    text.delete();
    add_code_point(21'h0, 1);
    add_code_point(21'h7f, 1);
    add_code_point(21'h80, 2);
    add_code_point(21'h7ff, 2);
    add_code_point(21'h800, 3);
    add_code_point(21'hd7ff, 3);
    add_code_point(21'hffff, 3);
    add_code_point(21'h10000, 4);
    add_code_point(21'h10ffff, 4);
    send_frame();

    // Random frames under a series of limits, extremes first.
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph)
        0: lim = 32'd1;
        1: lim = 32'hffff_ffff;
        2: lim = $urandom_range(2, 16);
        3: lim = $urandom_range(17, 300);
        4: lim = MAX_PAYLOAD_RST;
        default: lim = $urandom() | 32'h1;
      endcase
      write_max_payload(lim);
      if (ph == 1) begin
        // Long frame while the receiver holds off: input must back up.
        hold_off_req = 1'b1;
        text.delete();
        fill_text(80);
        send_frame();
      end
      quota = bytes_sent + PHASE_BYTES;
      while (bytes_sent < quota) send_random_frame();
    end

    // Close with one broken frame, then keep feeding the halted block.
    fault = fault_t'($urandom_range(FAULT_ZERO_LEN, FAULT_TRUNCATED));
    wait_idle();
    if (fault == FAULT_ZERO_LEN || fault == FAULT_OVER_LEN) begin
      lim = $urandom_range(1, 64);
      write_max_payload(lim);
      if (fault == FAULT_ZERO_LEN) send_length(32'h0);
      else send_length($urandom_range(0, 1) ? 32'hffff_ffff : lim + 32'd1);
    end else begin
      build_faulty_text(fault);
      write_max_payload(text.size() + $urandom_range(0, 50));
      send_frame();
    end
    repeat ($urandom_range(20, 40)) begin
      offer_byte(8'($urandom_range(0, 255)));
      halted_bytes++;
    end

    // Drain; the watchdog bounds this wait.
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d byte transactions under %0d max_payload settings; %0d frames passed, %0d results checked.",
             bytes_sent, limit_writes, frames_passed, results_checked);
    $display("Ended on a %s frame, then %0d bytes into the halted block; %0d long receiver hold(s).",
             fault.name(), halted_bytes, holds_done);
    if (mismatches == 0 && results_owed == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #10ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[length_prefixed_utf8_deframer_unit.f]
hw/rtl/lpud_pkg.sv
hw/rtl/lpud_if.sv
hw/rtl/lpud_front.sv
hw/rtl/lpud_queue.sv
hw/rtl/lpud_back.sv
hw/rtl/length_prefixed_utf8_deframer_unit.sv
tb/sv/deframe_checker.sv
tb/sv/length_prefixed_utf8_deframer_unit_test.sv
